FILE: sv/usb_ep0_control_handler_defines.svh
// ----------------------------------------------------------------------------
// USB endpoint-zero control handler: assertion macros
// Concurrent checks on clock, disabled in reset; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef USB_EP0_CONTROL_HANDLER_DEFINES_SVH
`define USB_EP0_CONTROL_HANDLER_DEFINES_SVH

`ifndef SYNTH
`define UEP0_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("uep0 check failed");
`define UEP0_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("uep0 check failed");
`else
`define UEP0_ASSERT_IMP(label, ante, cons)
`define UEP0_ASSERT_NXT(label, ante, cons)
`endif

`endif

FILE: sv/uep0_pkg.sv
// ----------------------------------------------------------------------------
// uep0_pkg
// Types, codes and constants of the endpoint-zero control handler.
// ----------------------------------------------------------------------------
package uep0_pkg;

   localparam int DEFAULT_MAX_PACKET = 16;

   typedef enum logic [2:0] {
      EVT_SETUP    = 3'd0,
      EVT_OUT_DATA = 3'd1,
      EVT_IN_DONE  = 3'd2,
      EVT_BUS_RST  = 3'd3,
      EVT_OTHER    = 3'd4
   } event_type;

   typedef enum logic [2:0] {
      ACT_NONE      = 3'd0,
      ACT_CHUNK     = 3'd1,
      ACT_ZLP       = 3'd2,
      ACT_CFG_BYTE  = 3'd3,
      ACT_SET_ADDR  = 3'd4,
      ACT_ENABLE_EP = 3'd5,
      ACT_CLASS     = 3'd6
   } action_type;

   typedef enum logic [2:0] {
      ST_NOT_ATTACHED = 3'd0,
      ST_ATTACHED     = 3'd1,
      ST_POWERED      = 3'd2,
      ST_DEFAULT      = 3'd3,
      ST_ADDRESS      = 3'd4,
      ST_CONFIGURED   = 3'd5
   } dev_state_type;

   localparam logic [1:0] RT_STANDARD = 2'd0;
   localparam logic [1:0] RT_CLASS    = 2'd1;

   localparam logic [7:0] RQ_SET_ADDRESS       = 8'd5;
   localparam logic [7:0] RQ_GET_DESCRIPTOR    = 8'd6;
   localparam logic [7:0] RQ_GET_CONFIGURATION = 8'd8;
   localparam logic [7:0] RQ_SET_CONFIGURATION = 8'd9;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [7:0]  setup_request_type;
      logic [7:0]  setup_request;
      logic [15:0] setup_value;
      logic [15:0] setup_length;
      logic [7:0]  descriptor_length;
   } req_item_type;

   typedef struct packed {
      action_type  action;
      logic [7:0]  chunk_offset;
      logic [4:0]  chunk_length;
      logic [7:0]  descriptor_type;
      logic [7:0]  descriptor_number;
      logic [7:0]  device_address;
      logic [7:0]  config_value;
      logic [2:0]  device_state;
   } rsp_item_type;

   typedef struct packed {
      logic [7:0]    bytes_left;
      logic [7:0]    send_offset;
      logic          zlp_pending;
      logic [7:0]    current_config;
      dev_state_type usb_state;
      logic [15:0]   active_descriptor;
   } ep0_state_type;

endpackage

FILE: sv/uep0_if.sv
// ----------------------------------------------------------------------------
// uep0 channel interfaces
// Valid/ready channels for endpoint-zero events and handler responses.
// ----------------------------------------------------------------------------
interface uep0_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  req_type;
   logic [7:0]  setup_request_type;
   logic [7:0]  setup_request;
   logic [15:0] setup_value;
   logic [15:0] setup_length;
   logic [7:0]  descriptor_length;

   modport source (output valid, req_type, setup_request_type, setup_request,
                   setup_value, setup_length, descriptor_length, input ready);
   modport sink (input valid, req_type, setup_request_type, setup_request,
                 setup_value, setup_length, descriptor_length, output ready);
endinterface

interface uep0_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic [7:0]  chunk_offset;
   logic [4:0]  chunk_length;
   logic [7:0]  descriptor_type;
   logic [7:0]  descriptor_number;
   logic [7:0]  device_address;
   logic [7:0]  config_value;
   logic [2:0]  device_state;

   modport source (output valid, action, chunk_offset, chunk_length, descriptor_type,
                   descriptor_number, device_address, config_value, device_state,
                   input ready);
   modport sink (input valid, action, chunk_offset, chunk_length, descriptor_type,
                 descriptor_number, device_address, config_value, device_state,
                 output ready);
endinterface

FILE: sv/uep0_core.sv
// ----------------------------------------------------------------------------
// uep0_core
// Request decode and transfer bookkeeping for one event: next state and response.
// ----------------------------------------------------------------------------
module uep0_core #(
   parameter int MAX_PACKET = uep0_pkg::DEFAULT_MAX_PACKET
) (
   input  uep0_pkg::req_item_type  item,
   input  uep0_pkg::ep0_state_type state_cur,
   output uep0_pkg::ep0_state_type state_nxt,
   output uep0_pkg::rsp_item_type  rsp
);

   localparam logic [7:0] MaxPkt = 8'(MAX_PACKET);

   logic [1:0]  rtype;
   logic        get_desc;
   logic [7:0]  xfer_len;
   logic [7:0]  src_bytes;
   logic [7:0]  src_offset;
   logic [15:0] src_desc;
   logic [7:0]  chunk_n;

   assign rtype    = item.setup_request_type[6:5];
   assign get_desc = (item.req_type == uep0_pkg::EVT_SETUP) &&
                     (rtype == uep0_pkg::RT_STANDARD) &&
                     (item.setup_request == uep0_pkg::RQ_GET_DESCRIPTOR);
   assign xfer_len = (item.setup_length < {8'd0, item.descriptor_length}) ?
                     item.setup_length[7:0] : item.descriptor_length;

   // new transfer starts from the setup fields, continuation from held state
   assign src_bytes  = get_desc ? xfer_len : state_cur.bytes_left;
   assign src_offset = get_desc ? 8'd0 : state_cur.send_offset;
   assign src_desc   = get_desc ? item.setup_value : state_cur.active_descriptor;
   assign chunk_n    = (src_bytes > MaxPkt) ? MaxPkt : src_bytes;

   always_comb begin
      state_nxt = state_cur;
      rsp       = '0;
      rsp.action = uep0_pkg::ACT_NONE;
      case (item.req_type)
         uep0_pkg::EVT_SETUP: begin
            if (rtype == uep0_pkg::RT_STANDARD) begin
               case (item.setup_request)
                  uep0_pkg::RQ_GET_DESCRIPTOR: begin
                     state_nxt.active_descriptor = src_desc;
                     state_nxt.zlp_pending       = 1'b0;
                  end
                  uep0_pkg::RQ_SET_ADDRESS: begin
                     state_nxt.usb_state = uep0_pkg::ST_ADDRESS;
                     rsp.action          = uep0_pkg::ACT_SET_ADDR;
                     rsp.device_address  = item.setup_value[7:0];
                  end
                  uep0_pkg::RQ_SET_CONFIGURATION: begin
                     state_nxt.usb_state      = uep0_pkg::ST_CONFIGURED;
                     state_nxt.current_config = item.setup_value[7:0];
                     rsp.action               = uep0_pkg::ACT_ENABLE_EP;
                     rsp.config_value         = item.setup_value[7:0];
                  end
                  uep0_pkg::RQ_GET_CONFIGURATION: begin
                     rsp.action       = uep0_pkg::ACT_CFG_BYTE;
                     rsp.config_value = state_cur.current_config;
                  end
                  default: begin
                  end
               endcase
            end else if (rtype == uep0_pkg::RT_CLASS) begin
               rsp.action = uep0_pkg::ACT_CLASS;
            end
         end
         uep0_pkg::EVT_OUT_DATA: begin
            rsp.action = uep0_pkg::ACT_ZLP;
         end
         uep0_pkg::EVT_IN_DONE: begin
            if (state_cur.bytes_left == 8'd0 && state_cur.zlp_pending) begin
               state_nxt.zlp_pending = 1'b0;
               rsp.action            = uep0_pkg::ACT_ZLP;
            end
         end
         uep0_pkg::EVT_BUS_RST: begin
            state_nxt.usb_state = uep0_pkg::ST_DEFAULT;
         end
         default: begin
         end
      endcase

      if (get_desc || (item.req_type == uep0_pkg::EVT_IN_DONE &&
                       state_cur.bytes_left != 8'd0)) begin
         rsp.action            = uep0_pkg::ACT_CHUNK;
         rsp.chunk_offset      = src_offset;
         rsp.chunk_length      = chunk_n[4:0];
         rsp.descriptor_type   = src_desc[15:8];
         rsp.descriptor_number = src_desc[7:0];
         state_nxt.bytes_left  = src_bytes - chunk_n;
         state_nxt.send_offset = src_offset + chunk_n;
         if (src_bytes == chunk_n && chunk_n == MaxPkt) begin
            state_nxt.zlp_pending = 1'b1;
         end
      end

      rsp.device_state = state_nxt.usb_state;
   end

endmodule

FILE: sv/usb_ep0_control_handler.sv
// ----------------------------------------------------------------------------
// usb_ep0_control_handler
// Endpoint-zero control handler: standard request decode, descriptor chunking
// and device state tracking, one response per event.
// ----------------------------------------------------------------------------
//  channel   | port      | dir | carries
//  ----------+-----------+-----+---------------------------------------------
//  request   | req_chan  | in  | ep0 event: type, setup fields, descr length
//  response  | rsp_chan  | out | action, chunk, address, config, device state
//
//  One event per cycle sustained while rsp_chan is not stalled; each event
//  passes the input register, then the response register, before its
//  response handshake.
//  Transfer and device state are updated as an event leaves the input register.
//  A stalled response holds the response register; the input register still
//  takes one more transaction before req_chan.ready drops.
//  Synchronous reset: device not attached, no transfer pending.
// ----------------------------------------------------------------------------
`include "usb_ep0_control_handler_defines.svh"

module usb_ep0_control_handler #(
   parameter int MAX_PACKET = uep0_pkg::DEFAULT_MAX_PACKET
) (
   input logic      clock,
   input logic      reset,
   uep0_req_if.sink   req_chan,
   uep0_rsp_if.source rsp_chan
);

   logic                    s1_valid_ff;
   uep0_pkg::req_item_type  s1_item_ff;
   logic                    rsp_valid_ff;
   uep0_pkg::rsp_item_type  rsp_ff;
   uep0_pkg::ep0_state_type state_ff;

   uep0_pkg::ep0_state_type state_in;
   uep0_pkg::rsp_item_type  rsp_in;
   uep0_pkg::req_item_type  req_item;
   logic                    advance;
   logic                    req_accept;

   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !s1_valid_ff || advance;

   assign req_item.req_type           = req_chan.req_type;
   assign req_item.setup_request_type = req_chan.setup_request_type;
   assign req_item.setup_request      = req_chan.setup_request;
   assign req_item.setup_value        = req_chan.setup_value;
   assign req_item.setup_length       = req_chan.setup_length;
   assign req_item.descriptor_length  = req_chan.descriptor_length;

   uep0_core #(
      .MAX_PACKET(MAX_PACKET)
   ) u_core (
      .item     (s1_item_ff),
      .state_cur(state_ff),
      .state_nxt(state_in),
      .rsp      (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '{bytes_left: 8'd0, send_offset: 8'd0, zlp_pending: 1'b0,
                           current_config: 8'd0, usb_state: uep0_pkg::ST_NOT_ATTACHED,
                           active_descriptor: 16'd0};
      end else begin
         if (req_chan.ready) begin
            s1_valid_ff <= req_chan.valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_accept) begin
         s1_item_ff <= req_item;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.action            = rsp_ff.action;
   assign rsp_chan.chunk_offset      = rsp_ff.chunk_offset;
   assign rsp_chan.chunk_length      = rsp_ff.chunk_length;
   assign rsp_chan.descriptor_type   = rsp_ff.descriptor_type;
   assign rsp_chan.descriptor_number = rsp_ff.descriptor_number;
   assign rsp_chan.device_address    = rsp_ff.device_address;
   assign rsp_chan.config_value      = rsp_ff.config_value;
   assign rsp_chan.device_state      = rsp_ff.device_state;

   // zlp only ever queued once the transfer has drained
   `UEP0_ASSERT_IMP(a_zlp_drained, state_ff.zlp_pending, state_ff.bytes_left == 8'd0)
   `UEP0_ASSERT_NXT(a_accept_loads, req_accept, s1_valid_ff)
   `UEP0_ASSERT_NXT(a_advance_rsp, advance, rsp_valid_ff)
   `UEP0_ASSERT_NXT(a_bus_reset_state, advance && s1_item_ff.req_type == uep0_pkg::EVT_BUS_RST,
                    rsp_ff.device_state == uep0_pkg::ST_DEFAULT)

endmodule

FILE: tb/tb_usb_ep0_control_handler.sv
// ----------------------------------------------------------------------------
// tb_usb_ep0_control_handler
// Drives endpoint-zero events into the handler and checks every response
// against a cycle-free predictor of the transfer and device state: descriptor
// chunking, zero-length packets, address/configuration requests, class
// forwarding and bus reset. Directed corner cases first, then random request
// sequences with random gaps on both channels.
// ----------------------------------------------------------------------------
import uep0_pkg::*;

class ep0_action_predictor #(int PKT = 16);
   logic [7:0]    bytes_left;
   logic [7:0]    send_offset;
   logic          zlp_pending;
   logic [7:0]    current_config;
   dev_state_type usb_state;
   logic [15:0]   active_descriptor;
   rsp_item_type  due_responses[$];
   int            mismatches;
   int            action_seen[8];

   function new();
      bytes_left        = '0;
      send_offset       = '0;
      zlp_pending       = 1'b0;
      current_config    = '0;
      usb_state         = ST_NOT_ATTACHED;
      active_descriptor = '0;
      mismatches        = 0;
      foreach (action_seen[i]) action_seen[i] = 0;
   endfunction

   function int pending();
      return due_responses.size();
   endfunction

   task report(string what);
      mismatches++;
      if (mismatches <= 40) $display("MISMATCH at %0t: %s", $time, what);
   endtask

   function rsp_item_type next_chunk();
      rsp_item_type r;
      logic [7:0]   n;
      r = '0;
      n = (bytes_left > PKT) ? 8'(PKT) : bytes_left;
      r.action            = ACT_CHUNK;
      r.chunk_offset      = send_offset;
      r.chunk_length      = n[4:0];
      r.descriptor_type   = active_descriptor[15:8];
      r.descriptor_number = active_descriptor[7:0];
      bytes_left  = bytes_left - n;
      send_offset = send_offset + n;
      if (bytes_left == 0 && n == PKT) zlp_pending = 1'b1;
      return r;
   endfunction

   function void note_event(req_item_type ev);
      rsp_item_type r;
      logic [15:0]  span;
      r = '0;
      case (ev.req_type)
         EVT_SETUP: begin
            if (ev.setup_request_type[6:5] == RT_STANDARD) begin
               case (ev.setup_request)
                  RQ_GET_DESCRIPTOR: begin
                     span = (16'(ev.descriptor_length) < ev.setup_length) ?
                            16'(ev.descriptor_length) : ev.setup_length;
                     active_descriptor = ev.setup_value;
                     bytes_left        = span[7:0];
                     send_offset       = '0;
                     zlp_pending       = 1'b0;
                     r = next_chunk();
                  end
                  RQ_SET_ADDRESS: begin
                     usb_state        = ST_ADDRESS;
                     r.action         = ACT_SET_ADDR;
                     r.device_address = ev.setup_value[7:0];
                  end
                  RQ_SET_CONFIGURATION: begin
                     usb_state      = ST_CONFIGURED;
                     current_config = ev.setup_value[7:0];
                     r.action       = ACT_ENABLE_EP;
                     r.config_value = current_config;
                  end
                  RQ_GET_CONFIGURATION: begin
                     r.action       = ACT_CFG_BYTE;
                     r.config_value = current_config;
                  end
                  default: ;
               endcase
            end else if (ev.setup_request_type[6:5] == RT_CLASS) begin
               r.action = ACT_CLASS;
            end
         end
         EVT_OUT_DATA: r.action = ACT_ZLP;
         EVT_IN_DONE: begin
            if (bytes_left != 0) begin
               r = next_chunk();
            end else if (zlp_pending) begin
               zlp_pending = 1'b0;
               r.action    = ACT_ZLP;
            end
         end
         EVT_BUS_RST: usb_state = ST_DEFAULT;
         default: ;
      endcase
      r.device_state = usb_state;
      due_responses.push_back(r);
   endfunction

   task compare_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   task check_response(rsp_item_type got);
      rsp_item_type want;
      if (due_responses.size() == 0) begin
         report("response with no transaction outstanding");
         return;
      end
      want = due_responses.pop_front();
      if (!$isunknown(got.action)) action_seen[got.action]++;
      compare_field("action", 8'(got.action), 8'(want.action));
      compare_field("chunk_offset", got.chunk_offset, want.chunk_offset);
      compare_field("chunk_length", 8'(got.chunk_length), 8'(want.chunk_length));
      compare_field("descriptor_type", got.descriptor_type, want.descriptor_type);
      compare_field("descriptor_number", got.descriptor_number, want.descriptor_number);
      compare_field("device_address", got.device_address, want.device_address);
      compare_field("config_value", got.config_value, want.config_value);
      compare_field("device_state", 8'(got.device_state), 8'(want.device_state));
   endtask
endclass

module tb_usb_ep0_control_handler;
   localparam int         PKT           = DEFAULT_MAX_PACKET;
   localparam int         EVENT_COUNT   = 1900;
   localparam logic [1:0] RT_VENDOR     = 2'd2;
   localparam logic [1:0] RT_RESERVED   = 2'd3;
   localparam logic [7:0] RQ_GET_STATUS = 8'd0;

   logic clock;
   logic reset;
   logic steady;
   int   sent;

   uep0_req_if req_chan();
   uep0_rsp_if rsp_chan();

   ep0_action_predictor #(PKT) predictor;

   usb_ep0_control_handler #(.MAX_PACKET(PKT)) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Timeout: handshake stalled");
      $display("Mismatches found");
      $finish;
   end

   always @(posedge clock) begin
      rsp_chan.ready <= !reset && (steady || $urandom_range(99) >= 35);
   end

   always @(posedge clock) begin
      rsp_item_type got;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         got.action            = action_type'(rsp_chan.action);
         got.chunk_offset      = rsp_chan.chunk_offset;
         got.chunk_length      = rsp_chan.chunk_length;
         got.descriptor_type   = rsp_chan.descriptor_type;
         got.descriptor_number = rsp_chan.descriptor_number;
         got.device_address    = rsp_chan.device_address;
         got.config_value      = rsp_chan.config_value;
         got.device_state      = rsp_chan.device_state;
         predictor.check_response(got);
      end
   end

   function automatic req_item_type make_event(logic [2:0] kind, logic [7:0] rtype,
                                              logic [7:0] rq, logic [15:0] val,
                                              logic [15:0] len, logic [7:0] dlen);
      req_item_type ev;
      ev.req_type           = kind;
      ev.setup_request_type = rtype;
      ev.setup_request      = rq;
      ev.setup_value        = val;
      ev.setup_length       = len;
      ev.descriptor_length  = dlen;
      return ev;
   endfunction

   // random direction and recipient bits around the type field
   function automatic logic [7:0] rt_byte(logic [1:0] kind);
      return {1'($urandom), kind, 5'($urandom)};
   endfunction

   function automatic req_item_type random_event(logic [2:0] kind);
      return make_event(kind, 8'($urandom), 8'($urandom), 16'($urandom),
                        16'($urandom), 8'($urandom));
   endfunction

   task automatic send_event(input req_item_type ev);
      while (!steady && $urandom_range(99) < 35) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid              <= 1'b1;
      req_chan.req_type           <= ev.req_type;
      req_chan.setup_request_type <= ev.setup_request_type;
      req_chan.setup_request      <= ev.setup_request;
      req_chan.setup_value        <= ev.setup_value;
      req_chan.setup_length       <= ev.setup_length;
      req_chan.descriptor_length  <= ev.descriptor_length;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
      predictor.note_event(ev);
      sent++;
      if (sent == 600) steady <= 1'b1;
      if (sent == 900) steady <= 1'b0;
   endtask

   initial begin
      req_item_type opening[$];
      logic [7:0]   std_in;
      logic [7:0]   dlen;
      logic [15:0]  wlen;
      int           span;
      int           ins;
      int           pick;
      int           k;
      bit           drained;

      predictor = new();
      reset                       = 1'b1;
      steady                      = 1'b0;
      sent                        = 0;
      drained                     = 1'b0;
      req_chan.valid              = 1'b0;
      req_chan.req_type           = EVT_OTHER;
      req_chan.setup_request_type = '0;
      req_chan.setup_request      = '0;
      req_chan.setup_value        = '0;
      req_chan.setup_length       = '0;
      req_chan.descriptor_length  = '0;
      rsp_chan.ready              = 1'b0;
      std_in = {1'b1, RT_STANDARD, 5'd0};

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      opening.push_back(make_event(EVT_IN_DONE, '0, '0, '0, '0, '0));
      for (k = int'(EVT_OTHER); k < 8; k++)
         opening.push_back(make_event(3'(k), '1, '1, '1, '1, '1));
      opening.push_back(make_event(EVT_BUS_RST, '0, '0, '0, '0, '0));
      opening.push_back(make_event(EVT_OUT_DATA, std_in, RQ_GET_DESCRIPTOR, '1, '1, '1));
      opening.push_back(make_event(EVT_SETUP, std_in, RQ_SET_ADDRESS, '1, '0, '0));
      opening.push_back(make_event(EVT_SETUP, std_in, RQ_GET_DESCRIPTOR, 16'h0100, '1, 8'd18));
      opening.push_back(make_event(EVT_IN_DONE, '0, '0, '0, '0, '0));
      opening.push_back(make_event(EVT_IN_DONE, '0, '0, '0, '0, '0));
      // exact multiple of the packet size: zlp closes the transfer
      opening.push_back(make_event(EVT_SETUP, std_in, RQ_GET_DESCRIPTOR, 16'h0200, 16'd32, '1));
      opening.push_back(make_event(EVT_IN_DONE, '0, '0, '0, '0, '0));
      opening.push_back(make_event(EVT_IN_DONE, '0, '0, '0, '0, '0));
      opening.push_back(make_event(EVT_IN_DONE, '0, '0, '0, '0, '0));
      // pending zlp dropped by a new, empty transfer
      opening.push_back(make_event(EVT_SETUP, std_in, RQ_GET_DESCRIPTOR, 16'h0300, 16'd16, 8'd16));
      opening.push_back(make_event(EVT_SETUP, std_in, RQ_GET_DESCRIPTOR, '1, '0, '1));
      opening.push_back(make_event(EVT_IN_DONE, '0, '0, '0, '0, '0));
      opening.push_back(make_event(EVT_SETUP, std_in, RQ_GET_DESCRIPTOR, 16'h0101, 16'd100, '0));
      opening.push_back(make_event(EVT_SETUP, '0, RQ_SET_CONFIGURATION, 16'h00ff, '0, '0));
      opening.push_back(make_event(EVT_SETUP, std_in, RQ_GET_CONFIGURATION, '0, 16'd1, '0));
      opening.push_back(make_event(EVT_SETUP, {1'b0, RT_CLASS, 5'd1}, 8'h0a, '0, '0, '0));
      opening.push_back(make_event(EVT_SETUP, {1'b0, RT_VENDOR, 5'd0}, RQ_GET_DESCRIPTOR,
                                   '1, '1, '1));
      opening.push_back(make_event(EVT_SETUP, '1, RQ_SET_ADDRESS, '1, '1, '1));
      opening.push_back(make_event(EVT_SETUP, std_in, RQ_GET_STATUS, '0, 16'd2, '0));
      opening.push_back(make_event(EVT_SETUP, std_in, '1, '1, '1, '1));
      // bus reset mid-transfer keeps the transfer going
      opening.push_back(make_event(EVT_SETUP, std_in, RQ_GET_DESCRIPTOR, 16'h0201, 16'd40, 8'd40));
      opening.push_back(make_event(EVT_BUS_RST, '0, '0, '0, '0, '0));
      opening.push_back(make_event(EVT_IN_DONE, '0, '0, '0, '0, '0));
      foreach (opening[i]) send_event(opening[i]);

      while (sent < EVENT_COUNT) begin
         if (!drained && sent >= 1000) begin
            drained = 1'b1;
            req_chan.valid <= 1'b0;
            @(posedge clock);
            while (predictor.pending() != 0) @(posedge clock);
         end
         pick = $urandom_range(99);
         if (pick < 45) begin
            dlen = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(64));
            wlen = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(80));
            span = (16'(dlen) < wlen) ? int'(dlen) : int'(wlen);
            send_event(make_event(EVT_SETUP, rt_byte(RT_STANDARD), RQ_GET_DESCRIPTOR,
                                  16'($urandom), wlen, dlen));
            ins = span / PKT + 1 + $urandom_range(2);
            for (k = 0; k < ins; k++) begin
               if ($urandom_range(9) == 0)
                  send_event(random_event(3'($urandom_range(int'(EVT_OUT_DATA), 7))));
               send_event(random_event(EVT_IN_DONE));
            end
         end else if (pick < 65) begin
            case ($urandom_range(3))
               0: send_event(make_event(EVT_SETUP, rt_byte(RT_STANDARD), RQ_SET_ADDRESS,
                                        16'($urandom), 16'($urandom), 8'($urandom)));
               1: send_event(make_event(EVT_SETUP, rt_byte(RT_STANDARD), RQ_SET_CONFIGURATION,
                                        16'($urandom), 16'($urandom), 8'($urandom)));
               2: send_event(make_event(EVT_SETUP, rt_byte(RT_STANDARD), RQ_GET_CONFIGURATION,
                                        16'($urandom), 16'($urandom), 8'($urandom)));
               default: send_event(make_event(EVT_SETUP, rt_byte(RT_STANDARD), 8'($urandom),
                                              16'($urandom), 16'($urandom), 8'($urandom)));
            endcase
         end else if (pick < 75) begin
            send_event(make_event(EVT_SETUP, rt_byte(RT_CLASS), 8'($urandom),
                                  16'($urandom), 16'($urandom), 8'($urandom)));
         end else if (pick < 82) begin
            send_event(make_event(EVT_SETUP,
                                  rt_byte($urandom_range(1) ? RT_VENDOR : RT_RESERVED),
                                  8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom)));
         end else begin
            send_event(random_event(3'($urandom)));
         end
      end

      req_chan.valid <= 1'b0;
      while (predictor.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Run covered %0d events: %0d chunks, %0d zero-length packets, %0d idle replies",
               sent, predictor.action_seen[ACT_CHUNK], predictor.action_seen[ACT_ZLP],
               predictor.action_seen[ACT_NONE]);
      $display("plus %0d address, %0d enable, %0d config reads and %0d class forwards",
               predictor.action_seen[ACT_SET_ADDR], predictor.action_seen[ACT_ENABLE_EP],
               predictor.action_seen[ACT_CFG_BYTE], predictor.action_seen[ACT_CLASS]);
      if (predictor.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
